/* hdl/sha1s_pkg.sv */
// Shared types and constants for the streaming SHA-1 hasher.
// No dependencies; imported by the hasher, block memory, round unit, digest checker and testbench.
package sha1s_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_HAND
  } sha1s_state_t;

  // Kind of block being compressed
  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD1,
    BLK_PAD2
  } sha1s_blk_t;

  typedef logic [4:0][31:0] sha1s_chain_t;

  // Controls from the sequencer to the round unit
  typedef struct packed {
    logic       load;
    logic       step;
    logic       add;
    logic       reinit;
    logic [6:0] rnd;
  } sha1s_ctl_t;

  // What the block read path needs to pad the final block(s)
  typedef struct packed {
    sha1s_blk_t  mode;
    logic [60:0] count;
  } sha1s_pad_t;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam sha1s_chain_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_INDEX = 3'd4;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

/* hdl/sha1s_if.sv */
// Handshake channels for the SHA-1 hasher: byte input and digest output.
// Depends on nothing.
interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* hdl/sha1_stream_hasher.sv */
// Streaming SHA-1 hasher, top level. Uses sha1s_pkg, sha1s_if, sha1s_block_mem, sha1s_round.
// A word that completes no block is accepted without a stall; a full block stalls input
// while the memory is primed, 80 rounds run on the one round unit and the chain is added.
// End of message adds one or two pad blocks, then a handoff state (held
// until the previous digest drains), then five digest words at up to one per cycle.
// Reset (sync, active high): chain = SHA-1 IV, count = 0; block memory not cleared.
module sha1_stream_hasher import sha1s_pkg::*; (
  input logic          clk,
  input logic          rst,
  sha1s_in_if.sink     in_ch,
  sha1s_out_if.source  out_ch
);

  sha1s_state_t state, state_next;
  sha1s_blk_t   mode, mode_next;
  logic [6:0]   rnd, rnd_next;
  logic [60:0]  count;
  logic         fin;
  logic         obusy;
  logic [2:0]   oidx;
  logic [31:0]  dig [5];

  sha1s_ctl_t   ctl;
  sha1s_pad_t   pad;
  sha1s_chain_t chain;
  logic [3:0]   rd_addr;
  logic [31:0]  w_word;
  logic         acc, out_acc, wr_en;

  assign in_ch.ready = (state == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign wr_en       = acc && in_ch.has_byte;
  assign out_acc     = out_ch.valid && out_ch.ready;

  assign pad.mode  = mode;
  assign pad.count = count;

  always_comb begin
    state_next = state;
    mode_next  = mode;
    rnd_next   = rnd;
    ctl        = '0;
    ctl.rnd    = rnd;
    rd_addr    = '0;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (in_ch.has_byte && (count[5:0] == 6'd63)) begin
            state_next = ST_LOAD;
            mode_next  = BLK_DATA;
          end else if (in_ch.end_of_message) begin
            state_next = ST_LOAD;
            mode_next  = BLK_PAD1;
          end
        end
      end
      ST_LOAD: begin
        ctl.load   = 1'b1;
        rd_addr    = 4'd0;
        rnd_next   = '0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        ctl.step = 1'b1;
        rd_addr  = rnd[3:0] + 4'd1;
        if (rnd == LAST_ROUND) begin
          state_next = ST_ADD;
        end else begin
          rnd_next = rnd + 7'd1;
        end
      end
      ST_ADD: begin
        ctl.add = 1'b1;
        if (mode == BLK_DATA && fin) begin
          state_next = ST_LOAD;
          mode_next  = BLK_PAD1;
        end else if (mode == BLK_PAD1 && count[5:3] == 3'b111) begin
          // no room for the length: it goes in a second block
          state_next = ST_LOAD;
          mode_next  = BLK_PAD2;
        end else if (mode != BLK_DATA) begin
          state_next = ST_HAND;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_HAND: begin
        if (!obusy) begin
          ctl.reinit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode  <= BLK_DATA;
      rnd   <= '0;
      count <= '0;
      fin   <= 1'b0;
      obusy <= 1'b0;
      oidx  <= '0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      rnd   <= rnd_next;
      if (ctl.reinit) begin
        count <= '0;
        fin   <= 1'b0;
        obusy <= 1'b1;
        oidx  <= '0;
      end else begin
        if (wr_en) begin
          count <= count + 61'd1;
        end
        if (acc) begin
          fin <= in_ch.end_of_message;
        end
        if (out_acc) begin
          if (oidx == LAST_INDEX) begin
            obusy <= 1'b0;
          end else begin
            oidx <= oidx + 3'd1;
          end
        end
      end
    end
  end

  // digest buffer frees the hasher for the next message
  always_ff @(posedge clk) begin
    if (ctl.reinit) begin
      for (int i = 0; i < 5; i++) begin
        dig[i] <= chain[i];
      end
    end
  end

  assign out_ch.valid       = obusy;
  assign out_ch.digest_word = dig[oidx];
  assign out_ch.word_index  = oidx;
  assign out_ch.last_word   = (oidx == LAST_INDEX);

  sha1s_block_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[5:0]),
    .wr_data (in_ch.data_byte),
    .rd_addr (rd_addr),
    .pad     (pad),
    .w_out   (w_word)
  );

  sha1s_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .w_in  (w_word),
    .chain (chain)
  );

endmodule

/* hdl/sha1s_block_mem.sv */
// 64-byte block store as a 16 x 32-bit memory, byte writes, registered read.
// Padding (0x80, zeros, bit length) is applied on the read side. Uses sha1s_pkg.
module sha1s_block_mem import sha1s_pkg::*; (
  input  logic       clk,
  input  logic       wr_en,
  input  logic [5:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic [3:0] rd_addr,
  input  sha1s_pad_t pad,
  output logic [31:0] w_out
);

  logic [31:0] mem [16];
  logic [31:0] q;
  logic [3:0]  q_addr;
  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic        len_here;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end
    q      <= mem[rd_addr];
    q_addr <= rd_addr;
  end

  assign pos     = pad.count[5:0];
  assign bit_len = {pad.count, 3'b000};
  // Length goes in the last two words of the final pad block
  assign len_here = (q_addr[3:1] == 3'b111) &&
                    ((pad.mode == BLK_PAD2) ||
                     ((pad.mode == BLK_PAD1) && (pos[5:3] != 3'b111)));

  always_comb begin
    logic [5:0] b;
    logic [7:0] byte_in;
    w_out = q;
    for (int j = 0; j < 4; j++) begin
      b       = {q_addr, 2'(j)};
      byte_in = q[8 * (3 - j) +: 8];
      case (pad.mode)
        BLK_DATA: w_out[8 * (3 - j) +: 8] = byte_in;
        BLK_PAD1: begin
          if (b < pos) begin
            w_out[8 * (3 - j) +: 8] = byte_in;
          end else if (b == pos) begin
            w_out[8 * (3 - j) +: 8] = PAD_BYTE;
          end else begin
            w_out[8 * (3 - j) +: 8] = 8'h00;
          end
        end
        default: w_out[8 * (3 - j) +: 8] = 8'h00;
      endcase
    end
    if (len_here) begin
      w_out = q_addr[0] ? bit_len[31:0] : bit_len[63:32];
    end
  end

endmodule

/* hdl/sha1s_round.sv */
// SHA-1 round unit: working words a..e, 16-word schedule window, chaining words.
// One round per cycle under control of the sequencer. Uses sha1s_pkg.
module sha1s_round import sha1s_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  sha1s_ctl_t   ctl,
  input  logic [31:0]  w_in,
  output sha1s_chain_t chain
);

  logic [31:0] a, b, c, d, e;
  logic [31:0] sr [16];
  logic [31:0] wt, fn, kc, tmp;

  always_comb begin
    // first 16 rounds take message words, then the schedule recurrence
    if (ctl.rnd < 7'd16) begin
      wt = w_in;
    end else begin
      wt = rotl32(sr[13] ^ sr[8] ^ sr[2] ^ sr[0], 1);
    end
    if (ctl.rnd < 7'd20) begin
      fn = (b & c) | (~b & d);
      kc = K0;
    end else if (ctl.rnd < 7'd40) begin
      fn = b ^ c ^ d;
      kc = K1;
    end else if (ctl.rnd < 7'd60) begin
      fn = (b & c) | (b & d) | (c & d);
      kc = K2;
    end else begin
      fn = b ^ c ^ d;
      kc = K3;
    end
    tmp = rotl32(a, 5) + fn + e + kc + wt;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (ctl.step) begin
      a <= tmp;
      b <= a;
      c <= rotl32(b, 30);
      d <= c;
      e <= d;
    end
    if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        sr[i] <= sr[i + 1];
      end
      sr[15] <= wt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.reinit) begin
      chain <= IV;
    end else if (ctl.add) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

endmodule

/* hdl/sha1s_checker.sv */
// Port-level checks on the digest output of the SHA-1 hasher, bound to the top level.
// Uses only the top level's output channel, clock and reset.
module sha1s_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest word changed while stalled");

  // words of one digest come in order
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest word index out of sequence");

  // next digest after a last word starts at index zero
  a_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> !out_valid || word_index == 3'd0)
    else $error("digest did not restart at word zero");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_word == (word_index == 3'd4))
    else $error("last flag does not match word index");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .digest_word (out_ch.digest_word),
  .word_index  (out_ch.word_index),
  .last_word   (out_ch.last_word)
);

/* tb/sv/sha1_digest_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the streaming SHA-1 hasher: follows accepted input words,
// predicts each digest and compares every digest word. Uses sha1s_pkg.
module sha1_digest_checker import sha1s_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int unsigned mismatch_count,
  output int unsigned words_owed
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  sha1s_chain_t chain_words;
  logic [7:0]   block_bytes [64];
  logic [60:0]  byte_total;
  digest_word_t digest_due [$];
  int unsigned  errors = 0;

  function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned n);
    logic [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
    for (int r = 16; r < 80; r++)
      w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rol(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_words[0] = chain_words[0] + a;
    chain_words[1] = chain_words[1] + b;
    chain_words[2] = chain_words[2] + c;
    chain_words[3] = chain_words[3] + d;
    chain_words[4] = chain_words[4] + e;
  endfunction

  // One accepted input word; on end of message pads, finishes and queues the digest.
  function automatic void absorb_word(input logic [7:0] data, input logic has,
                                      input logic eom);
    int          pos;
    logic [63:0] bit_len;
    if (has) begin
      pos = int'(byte_total[5:0]);
      block_bytes[pos] = data;
      byte_total = byte_total + 61'd1;
      if (pos == 63) compress_block();
    end
    if (eom) begin
      bit_len = {byte_total, 3'b000};
      pos = int'(byte_total[5:0]);
      block_bytes[pos] = PAD_BYTE;
      for (int i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
      // no room for the length: extra pad block
      if (pos >= 56) begin
        compress_block();
        for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
      compress_block();
      for (int i = 0; i < 5; i++)
        digest_due.push_back('{word: chain_words[i], index: 3'(i), last: (i == 4)});
      chain_words = IV;
      byte_total = '0;
    end
  endfunction

  always @(posedge clk) begin
    digest_word_t seen, want;
    if (rst) begin
      chain_words = IV;
      byte_total = '0;
      digest_due.delete();
    end else begin
      if (in_valid && in_ready)
        absorb_word(in_data_byte, in_has_byte, in_end_of_message);
      if (out_valid && out_ready) begin
        seen = '{word: out_digest_word, index: out_word_index, last: out_last_word};
        if (digest_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected digest word %h index %0d last %0b",
                     seen.word, seen.index, seen.last);
        end else begin
          want = digest_due.pop_front();
          if (seen.word !== want.word || seen.index !== want.index ||
              seen.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                       want.word, want.index, want.last, seen.word, seen.index, seen.last);
          end
        end
      end
    end
    mismatch_count <= errors;
    words_owed <= digest_due.size();
  end

endmodule

/* tb/sv/sha1_stream_hasher_tb.sv */
`timescale 1ns / 1ps
// Top of the SHA-1 hasher testbench: clock, reset, bursty message stimulus,
// stalling digest receiver and verdict. Uses sha1s_pkg, sha1s_if, sha1_digest_checker.
module sha1_stream_hasher_tb import sha1s_pkg::*;;

  typedef enum int unsigned {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SPARSE,
    DRAIN_PERIODIC
  } drain_mode_t;

  logic        clk;
  logic        rst;
  int unsigned mismatch_count;
  int unsigned words_owed;
  int unsigned message_items = 0;
  int unsigned messages_sent = 0;
  int unsigned burst_left = 0;
  int unsigned pad_boundary [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  sha1s_in_if  in_ch ();
  sha1s_out_if out_ch ();

  sha1_stream_hasher dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha1_digest_checker chk (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_data_byte      (in_ch.data_byte),
    .in_has_byte       (in_ch.has_byte),
    .in_end_of_message (in_ch.end_of_message),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_digest_word   (out_ch.digest_word),
    .out_word_index    (out_ch.word_index),
    .out_last_word     (out_ch.last_word),
    .mismatch_count    (mismatch_count),
    .words_owed        (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Sender: bursts of random length, random gaps between them.
  task automatic push_word(input logic [7:0] b, input logic hb, input logic eom);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(32, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 1);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.has_byte <= hb;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (hb || eom) message_items++;
  endtask

  // Random bytes; closed either on the last byte or by a bare end word.
  task automatic send_message(input int unsigned len);
    logic        bare;
    int unsigned i;
    bare = (len == 0) || ($urandom_range(1, 0) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(9, 0) == 0) push_word(8'($urandom_range(255, 0)), 1'b0, 1'b0);
      push_word(8'($urandom_range(255, 0)), 1'b1, !bare && (i == len - 1));
    end
    if (bare) push_word(8'($urandom_range(255, 0)), 1'b0, 1'b1);
    messages_sent++;
  endtask

  // Receiver: stall pattern switches between modes after spans of random length.
  initial begin
    drain_mode_t mode;
    int unsigned span, phase;
    out_ch.ready = 1'b0;
    phase = 0;
    forever begin
      mode = drain_mode_t'($urandom_range(3, 0));
      span = $urandom_range(80, 8);
      repeat (span) begin
        @(posedge clk);
        phase++;
        case (mode)
          DRAIN_FREE:   out_ch.ready <= 1'b1;
          DRAIN_COIN:   out_ch.ready <= 1'($urandom_range(1, 0));
          DRAIN_SPARSE: out_ch.ready <= ($urandom_range(3, 0) == 0);
          default:      out_ch.ready <= (phase % 3) != 0;
        endcase
      end
    end
  end

  initial begin
    int unsigned pick, len;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.has_byte = 1'b0;
    in_ch.end_of_message = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty word, then two empty messages back to back
    push_word(8'hFF, 1'b0, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hA5, 1'b0, 1'b1);
    // "abc", closed on its last byte
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'h63, 1'b1, 1'b1);
    // single-byte messages at the byte extremes
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'hFF, 1'b1, 1'b1);
    // empty words inside a message, closed by a bare end word
    push_word(8'h80, 1'b1, 1'b0);
    push_word(8'h5A, 1'b0, 1'b0);
    push_word(8'hFF, 1'b1, 1'b0);
    push_word(8'hC3, 1'b0, 1'b0);
    push_word(8'h3C, 1'b0, 1'b1);

    // mostly short messages, some on the padding boundaries
    while (message_items < 400 || messages_sent < 12) begin
      pick = $urandom_range(9, 0);
      if (pick < 6) len = $urandom_range(12, 0);
      else if (pick < 8) len = pad_boundary[$urandom_range(9, 0)];
      else len = $urandom_range(140, 0);
      send_message(len);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && words_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sha1_stream_hasher.f */
hdl/sha1s_pkg.sv
hdl/sha1s_if.sv
hdl/sha1s_block_mem.sv
hdl/sha1s_round.sv
hdl/sha1_stream_hasher.sv
hdl/sha1s_checker.sv
tb/sv/sha1_digest_checker.sv
tb/sv/sha1_stream_hasher_tb.sv
